FILE: design/otok_pkg.sv
package otok_pkg;

    localparam int unsigned MAX_ARGS = 16;
    localparam int unsigned MAX_LEN  = 4096;

    localparam int unsigned POS_W = 13;
    localparam int unsigned OFF_W = 12;
    localparam int unsigned CNT_W = 5;

    localparam logic [7:0] CHAR_SEMICOLON = 8'h3B;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_DASH      = 8'h2D;
    localparam logic [7:0] CHAR_EQUALS    = 8'h3D;

    localparam logic KIND_TOKEN   = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] DASH_NONE   = 2'd0;
    localparam logic [1:0] DASH_ONE    = 2'd1;
    localparam logic [1:0] DASH_PREFIX = 2'd2;

    typedef struct packed {
        logic             result_kind;
        logic [OFF_W-1:0] key_start;
        logic [POS_W-1:0] key_length;
        logic             value_present;
        logic [POS_W-1:0] value_start;
        logic [POS_W-1:0] value_length;
        logic             payload_present;
        logic [POS_W-1:0] payload_start;
        logic [OFF_W-1:0] payload_length;
        logic [CNT_W-1:0] argument_count;
        logic             last_result;
    } otok_result_t;

    typedef struct packed {
        logic [1:0]   count;
        otok_result_t first;
        otok_result_t second;
    } otok_push_t;

endpackage

FILE: design/otok_stream_if.sv
interface otok_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       final_byte;

    modport source (output valid, byte_value, final_byte, input ready);
    modport sink (input valid, byte_value, final_byte, output ready);
endinterface

interface otok_result_if;
    logic                         valid;
    logic                         ready;
    logic                         result_kind;
    logic [otok_pkg::OFF_W-1:0]   key_start;
    logic [otok_pkg::POS_W-1:0]   key_length;
    logic                         value_present;
    logic [otok_pkg::POS_W-1:0]   value_start;
    logic [otok_pkg::POS_W-1:0]   value_length;
    logic                         payload_present;
    logic [otok_pkg::POS_W-1:0]   payload_start;
    logic [otok_pkg::OFF_W-1:0]   payload_length;
    logic [otok_pkg::CNT_W-1:0]   argument_count;
    logic                         last_result;

    modport source (
        output valid, result_kind, key_start, key_length, value_present, value_start,
               value_length, payload_present, payload_start, payload_length,
               argument_count, last_result,
        input  ready
    );
    modport sink (
        input  valid, result_kind, key_start, key_length, value_present, value_start,
               value_length, payload_present, payload_start, payload_length,
               argument_count, last_result,
        output ready
    );
endinterface

FILE: design/otok_in_stage.sv
module otok_in_stage (
    input  logic              clk,
    input  logic              rst_n,
    otok_byte_if.sink         byte_ch,
    input  logic              take,
    output logic              item_valid,
    output logic [7:0]        item_byte,
    output logic              item_final
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       final_reg;
    logic       load;

    assign byte_ch.ready = !valid_reg || take;
    assign load          = byte_ch.valid && byte_ch.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg  <= byte_ch.byte_value;
            final_reg <= byte_ch.final_byte;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;
    assign item_final = final_reg;

endmodule

FILE: design/otok_parse.sv
module otok_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  logic [7:0]           item_byte,
    input  logic                 item_final,
    input  logic [1:0]           space,
    output logic                 take,
    output otok_pkg::otok_push_t push
);

    typedef enum logic [1:0] {
        PH_SKIP,
        PH_TOKEN,
        PH_PAYLOAD
    } phase_t;

    phase_t                      phase_reg, phase_next;
    logic [otok_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [otok_pkg::OFF_W-1:0]  tbeg_reg, tbeg_next;
    logic [1:0]                  dash_reg, dash_next;
    logic                        eq_reg, eq_next;
    logic [otok_pkg::OFF_W-1:0]  eqpos_reg, eqpos_next;
    logic [otok_pkg::CNT_W-1:0]  tok_reg, tok_next;
    logic [otok_pkg::POS_W-1:0]  pbeg_reg, pbeg_next;

    logic                        in_range;
    logic                        is_semi;
    logic                        is_space;
    logic                        eq_open;
    logic                        close_sep;
    logic                        close_fin;
    logic                        emit;
    logic [1:0]                  need;
    logic [otok_pkg::POS_W-1:0]  tend;
    logic [otok_pkg::POS_W-1:0]  kstart;
    logic [otok_pkg::POS_W-1:0]  eq13;
    otok_pkg::otok_result_t      tok_res;
    otok_pkg::otok_result_t      sum_res;

    assign in_range = pos_reg < otok_pkg::POS_W'(otok_pkg::MAX_LEN);
    assign is_semi  = item_byte == otok_pkg::CHAR_SEMICOLON;
    assign is_space = (item_byte == otok_pkg::CHAR_SPACE) || (item_byte == otok_pkg::CHAR_TAB);

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        tbeg_next  = tbeg_reg;
        dash_next  = dash_reg;
        eq_next    = eq_reg;
        eqpos_next = eqpos_reg;
        pbeg_next  = pbeg_reg;
        close_sep  = 1'b0;
        eq_open    = eq_reg;
        if (in_range)
        begin
            pos_next = pos_reg + 1'b1;
            if (phase_reg == PH_PAYLOAD)
            begin
                pbeg_next = pbeg_reg;
            end
            else if (is_semi)
            begin
                close_sep  = phase_reg == PH_TOKEN;
                phase_next = PH_PAYLOAD;
                pbeg_next  = pos_reg + 1'b1;
            end
            else if (is_space)
            begin
                close_sep  = phase_reg == PH_TOKEN;
                phase_next = PH_SKIP;
            end
            else
            begin
                if (phase_reg == PH_SKIP)
                begin
                    phase_next = PH_TOKEN;
                    tbeg_next  = pos_reg[otok_pkg::OFF_W-1:0];
                    dash_next  = (item_byte == otok_pkg::CHAR_DASH) ?
                                 otok_pkg::DASH_ONE : otok_pkg::DASH_NONE;
                    eq_next    = 1'b0;
                    eqpos_next = '0;
                    eq_open    = 1'b0;
                end
                else if ((pos_reg == {1'b0, tbeg_reg} + 1'b1) &&
                         (dash_reg == otok_pkg::DASH_ONE) &&
                         (item_byte == otok_pkg::CHAR_DASH))
                begin
                    dash_next = otok_pkg::DASH_PREFIX;
                end
                if ((item_byte == otok_pkg::CHAR_EQUALS) && !eq_open)
                begin
                    eq_next    = 1'b1;
                    eqpos_next = pos_reg[otok_pkg::OFF_W-1:0];
                end
            end
        end
    end

    // A token still open at the final byte closes one past the last counted byte.
    assign close_fin = item_final && (phase_next == PH_TOKEN);
    assign tend      = close_sep ? pos_reg : pos_next;
    assign emit      = (close_sep || close_fin) &&
                       (tok_reg < otok_pkg::CNT_W'(otok_pkg::MAX_ARGS));
    assign tok_next  = tok_reg + otok_pkg::CNT_W'(emit);
    assign need      = 2'(emit) + 2'(item_final);
    assign take      = item_valid && (need <= space);

    assign kstart = {1'b0, tbeg_next} +
                    ((dash_next == otok_pkg::DASH_PREFIX) ? 13'd2 : 13'd0);
    assign eq13   = {1'b0, eqpos_next};

    always_comb
    begin
        tok_res                 = '0;
        tok_res.result_kind     = otok_pkg::KIND_TOKEN;
        tok_res.key_start       = kstart[otok_pkg::OFF_W] ? '1 : kstart[otok_pkg::OFF_W-1:0];
        tok_res.argument_count  = tok_next;
        tok_res.last_result     = 1'b0;
        if (eq_next)
        begin
            tok_res.value_present = 1'b1;
            tok_res.key_length    = eq13 - kstart;
            tok_res.value_start   = eq13 + 1'b1;
            tok_res.value_length  = tend - (eq13 + 1'b1);
        end
        else
        begin
            tok_res.key_length    = (tend >= kstart) ? (tend - kstart) : '0;
        end

        sum_res                 = '0;
        sum_res.result_kind     = otok_pkg::KIND_SUMMARY;
        sum_res.argument_count  = tok_next;
        sum_res.last_result     = 1'b1;
        if (phase_next == PH_PAYLOAD)
        begin
            sum_res.payload_present = 1'b1;
            sum_res.payload_start   = pbeg_next;
            sum_res.payload_length  = otok_pkg::OFF_W'(pos_next - pbeg_next);
        end
    end

    assign push.count  = take ? need : 2'd0;
    assign push.first  = emit ? tok_res : sum_res;
    assign push.second = sum_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            pos_reg   <= '0;
            tbeg_reg  <= '0;
            dash_reg  <= otok_pkg::DASH_NONE;
            eq_reg    <= 1'b0;
            eqpos_reg <= '0;
            tok_reg   <= '0;
            pbeg_reg  <= '0;
        end
        else if (take)
        begin
            if (item_final)
            begin
                phase_reg <= PH_SKIP;
                pos_reg   <= '0;
                tbeg_reg  <= '0;
                dash_reg  <= otok_pkg::DASH_NONE;
                eq_reg    <= 1'b0;
                eqpos_reg <= '0;
                tok_reg   <= '0;
                pbeg_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_next;
                pos_reg   <= pos_next;
                tbeg_reg  <= tbeg_next;
                dash_reg  <= dash_next;
                eq_reg    <= eq_next;
                eqpos_reg <= eqpos_next;
                tok_reg   <= tok_next;
                pbeg_reg  <= pbeg_next;
            end
        end
    end

endmodule

FILE: design/otok_out_queue.sv
module otok_out_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  otok_pkg::otok_push_t push,
    output logic [1:0]           space,
    otok_result_if.source        result_ch
);

    otok_pkg::otok_result_t q_reg [2];
    logic [1:0]             count_reg, count_next;
    logic                   rd_reg, rd_next;
    logic                   pop;
    logic                   wr0;
    otok_pkg::otok_result_t head;

    assign pop        = (count_reg != 2'd0) && result_ch.ready;
    assign space      = 2'd2 - count_reg + 2'(pop);
    assign wr0        = rd_reg ^ count_reg[0];
    assign rd_next    = rd_reg ^ pop;
    assign count_next = count_reg - 2'(pop) + push.count;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
            rd_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            rd_reg    <= rd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr0] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            q_reg[!wr0] <= push.second;
        end
    end

    assign head = q_reg[rd_reg];

    assign result_ch.valid           = count_reg != 2'd0;
    assign result_ch.result_kind     = head.result_kind;
    assign result_ch.key_start       = head.key_start;
    assign result_ch.key_length      = head.key_length;
    assign result_ch.value_present   = head.value_present;
    assign result_ch.value_start     = head.value_start;
    assign result_ch.value_length    = head.value_length;
    assign result_ch.payload_present = head.payload_present;
    assign result_ch.payload_start   = head.payload_start;
    assign result_ch.payload_length  = head.payload_length;
    assign result_ch.argument_count  = head.argument_count;
    assign result_ch.last_result     = head.last_result;

endmodule

FILE: design/osc_argument_tokenizer_core.sv
// A byte passes through the input register and the combinational parser into the
// two-entry result queue, whose registered head is then offered as the result.
// Throughput: one byte per cycle while the result queue has room; a final byte
// that closes a token pushes two results, and the queue pops one per cycle.
// Reset (rst_n, asynchronous, active low) empties the input register and the
// two-entry result queue and returns the tokenizer to skipping whitespace.
module osc_argument_tokenizer_core (
    input  logic          clk,
    input  logic          rst_n,
    otok_byte_if.sink     byte_ch,
    otok_result_if.source result_ch
);

    logic                 item_valid;
    logic [7:0]           item_byte;
    logic                 item_final;
    logic                 take;
    logic [1:0]           space;
    otok_pkg::otok_push_t push;

    otok_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_ch    (byte_ch),
        .take       (take),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_final (item_final)
    );

    otok_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_byte  (item_byte),
        .item_final (item_final),
        .space      (space),
        .take       (take),
        .push       (push)
    );

    otok_out_queue u_out_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .space     (space),
        .result_ch (result_ch)
    );

endmodule

FILE: design/otok_checker.sv
module otok_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       result_kind,
    input logic [otok_pkg::OFF_W-1:0] key_start,
    input logic [otok_pkg::POS_W-1:0] key_length,
    input logic                       value_present,
    input logic [otok_pkg::POS_W-1:0] value_length,
    input logic [otok_pkg::OFF_W-1:0] payload_length,
    input logic [otok_pkg::CNT_W-1:0] argument_count,
    input logic                       last_result
);

    logic in_accept;

    assign in_accept = in_valid && in_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind) &&
            $stable(key_length) && $stable(argument_count))
    else $error("Result changed while stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_accept, 2))
    else $error("Result appeared without an input transaction two edges earlier.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == otok_pkg::KIND_TOKEN) |->
            !last_result && (argument_count != '0) &&
            (argument_count <= otok_pkg::CNT_W'(otok_pkg::MAX_ARGS)) &&
            (payload_length == '0))
    else $error("Malformed token result.");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == otok_pkg::KIND_SUMMARY) |->
            last_result && (key_start == '0) && (key_length == '0) &&
            !value_present && (value_length == '0))
    else $error("Malformed summary result.");

endmodule

bind osc_argument_tokenizer_core otok_checker u_otok_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (byte_ch.valid),
    .in_ready       (byte_ch.ready),
    .out_valid      (result_ch.valid),
    .out_ready      (result_ch.ready),
    .result_kind    (result_ch.result_kind),
    .key_start      (result_ch.key_start),
    .key_length     (result_ch.key_length),
    .value_present  (result_ch.value_present),
    .value_length   (result_ch.value_length),
    .payload_length (result_ch.payload_length),
    .argument_count (result_ch.argument_count),
    .last_result    (result_ch.last_result)
);
